FILE: rtl/assert_macros.svh
// Assertion helpers used by msb_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/msb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_pkg
// Shared widths and defaults of the batch merge sorter.
// ----------------------------------------------------------------------------
package msb_pkg;
  localparam int DATA_W        = 32;
  localparam int MAX_ITEMS_DEF = 64;
endpackage

FILE: rtl/msb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_if
// Valid/ready channels: input elements and sorted results.
// ----------------------------------------------------------------------------
interface msb_in_if;
  import msb_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     batch_end;
  modport source (output valid, output value, output batch_end, input ready);
  modport sink   (input valid, input value, input batch_end, output ready);
endinterface

interface msb_out_if;
  import msb_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     run_end;
  logic                     overflow;
  modport source (output valid, output sorted_value, output run_end, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input run_end, input overflow,
                  output ready);
endinterface

FILE: rtl/msb_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_mem
// Element memory: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module msb_mem #(
  parameter int DEPTH = msb_pkg::MAX_ITEMS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [AW-1:0]                    waddr,
  input  logic signed [msb_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]                    raddr_a,
  input  logic [AW-1:0]                    raddr_b,
  output logic signed [msb_pkg::DATA_W-1:0] rd_data_a_r,
  output logic signed [msb_pkg::DATA_W-1:0] rd_data_b_r
);
  import msb_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_a_r <= mem[raddr_a];
    rd_data_b_r <= mem[raddr_b];
  end
endmodule

FILE: rtl/msb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_ctrl
// Sequencer: loads the batch, runs bottom-up merge passes between the two
// memories, then streams the sorted batch out.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msb_ctrl #(
  parameter int MAX_ITEMS = msb_pkg::MAX_ITEMS_DEF,
  parameter int AW        = $clog2(MAX_ITEMS)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  msb_in_if.sink                            in_ch,
  msb_out_if.source                         out_ch,
  output logic                              we0,
  output logic                              we1,
  output logic [AW-1:0]                     waddr,
  output logic signed [msb_pkg::DATA_W-1:0] wdata,
  output logic [AW-1:0]                     raddr_a,
  output logic [AW-1:0]                     raddr_b,
  input  logic signed [msb_pkg::DATA_W-1:0] rd0_a,
  input  logic signed [msb_pkg::DATA_W-1:0] rd0_b,
  input  logic signed [msb_pkg::DATA_W-1:0] rd1_a,
  input  logic signed [msb_pkg::DATA_W-1:0] rd1_b
);
  import msb_pkg::*;

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int XW = CW + 2;
  localparam logic [CW-1:0] NMAX = CW'(MAX_ITEMS);

  localparam logic [2:0] ST_LOAD    = 3'd0;
  localparam logic [2:0] ST_SETUP   = 3'd1;
  localparam logic [2:0] ST_RD      = 3'd2;
  localparam logic [2:0] ST_CMP     = 3'd3;
  localparam logic [2:0] ST_OUT_RD  = 3'd4;
  localparam logic [2:0] ST_OUT_CAP = 3'd5;
  localparam logic [2:0] ST_OUT     = 3'd6;

  logic [2:0]               state_r, state_nxt;
  logic [CW-1:0]            n_r, n_nxt;
  logic                     ovf_r, ovf_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     run_end_r, run_end_nxt;
  logic signed [DATA_W-1:0] out_data_r, out_data_nxt;
  logic                     src_r, src_nxt;
  logic [XW-1:0]            w_r, w_nxt;
  logic [XW-1:0]            lo_r, lo_nxt;
  logic [XW-1:0]            mid_r, mid_nxt;
  logic [XW-1:0]            hi_r, hi_nxt;
  logic [XW-1:0]            i_r, i_nxt;
  logic [XW-1:0]            j_r, j_nxt;
  logic [XW-1:0]            k_r, k_nxt;

  logic [XW-1:0]            n_x;
  logic [CW-1:0]            n_cnt;
  logic [XW-1:0]            sum_mid;
  logic [XW-1:0]            sum_hi;
  logic [XW-1:0]            w2;
  logic signed [DATA_W-1:0] head_a;
  logic signed [DATA_W-1:0] head_b;
  logic                     take_left;

  assign n_x     = {{(XW-CW){1'b0}}, n_r};
  assign sum_mid = lo_r + w_r;
  assign sum_hi  = lo_r + (w_r << 1);
  assign w2      = w_r << 1;
  assign head_a  = src_r ? rd1_a : rd0_a;
  assign head_b  = src_r ? rd1_b : rd0_b;
  assign take_left = (i_r < mid_r) && ((j_r >= hi_r) || (head_a <= head_b));

  assign in_ch.ready         = (state_r == ST_LOAD);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.sorted_value = out_data_r;
  assign out_ch.run_end      = run_end_r;
  assign out_ch.overflow     = ovf_r;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    run_end_nxt   = run_end_r;
    out_data_nxt  = out_data_r;
    src_nxt       = src_r;
    w_nxt         = w_r;
    lo_nxt        = lo_r;
    mid_nxt       = mid_r;
    hi_nxt        = hi_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    n_cnt         = n_r;
    we0           = 1'b0;
    we1           = 1'b0;
    waddr         = k_r[AW-1:0];
    wdata         = head_a;
    raddr_a       = i_r[AW-1:0];
    raddr_b       = j_r[AW-1:0];
    case (state_r)
      ST_LOAD: begin
        if (in_ch.valid) begin
          if (n_r < NMAX) begin
            we0   = 1'b1;
            waddr = n_r[AW-1:0];
            wdata = in_ch.value;
            n_cnt = n_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          n_nxt = n_cnt;
          if (in_ch.batch_end) begin
            w_nxt   = XW'(1);
            lo_nxt  = '0;
            k_nxt   = '0;
            src_nxt = 1'b0;
            state_nxt = (n_cnt <= CW'(1)) ? ST_OUT_RD : ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        mid_nxt   = (sum_mid < n_x) ? sum_mid : n_x;
        hi_nxt    = (sum_hi < n_x) ? sum_hi : n_x;
        i_nxt     = lo_r;
        j_nxt     = mid_nxt;
        k_nxt     = lo_r;
        state_nxt = ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        wdata = take_left ? head_a : head_b;
        we0   = src_r;
        we1   = !src_r;
        if (take_left) begin
          i_nxt = i_r + 1'b1;
        end else begin
          j_nxt = j_r + 1'b1;
        end
        k_nxt = k_r + 1'b1;
        if (k_nxt == hi_r) begin
          if (hi_r == n_x) begin
            w_nxt   = w2;
            src_nxt = !src_r;
            lo_nxt  = '0;
            if (w2 >= n_x) begin
              k_nxt     = '0;
              state_nxt = ST_OUT_RD;
            end else begin
              state_nxt = ST_SETUP;
            end
          end else begin
            lo_nxt    = hi_r;
            state_nxt = ST_SETUP;
          end
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_OUT_RD: begin
        raddr_a   = k_r[AW-1:0];
        state_nxt = ST_OUT_CAP;
      end
      ST_OUT_CAP: begin
        out_data_nxt  = head_a;
        out_valid_nxt = 1'b1;
        run_end_nxt   = ((k_r + 1'b1) == n_x);
        state_nxt     = ST_OUT;
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          if (run_end_r) begin
            n_nxt     = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      n_r         <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_end_r  <= run_end_nxt;
    out_data_r <= out_data_nxt;
    src_r      <= src_nxt;
    w_r        <= w_nxt;
    lo_r       <= lo_nxt;
    mid_r      <= mid_nxt;
    hi_r       <= hi_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
  end

  `ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, n_r <= NMAX)
  `ASSERT_IMP(a_one_writer, clk, rst_n, 1'b1, !(we0 && we1))
  `ASSERT_IMP(a_merge_in_block, clk, rst_n, state_r == ST_CMP, k_r < hi_r)
  `ASSERT_NXT(a_batch_clear, clk, rst_n, out_valid_r && out_ch.ready && run_end_r,
              n_r == '0 && !ovf_r && state_r == ST_LOAD)
endmodule

FILE: rtl/merge_sort_batch_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merge_sort_batch_top
// Batch sorter: stores signed elements, merge sorts them ascending between
// two memories and returns the sorted batch with the last result marked.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                              Handshake
// in_ch     in   value, batch_end                     valid/ready
// out_ch    out  sorted_value, run_end, overflow      valid/ready
//
// Load: one element per cycle, ready only while loading.
// Sort: ceil(log2 n) passes; in each pass every element is read from memory, then
//   compared and written, with a setup step per merged block pair, ping-ponging memories.
// Output: each result is read, captured and handed off before the next is read.
// Reset: synchronous active low; clears state, count, overflow and valid only, memories hold garbage.
// Stalls: out ready low holds the current result and the sequencer.
module merge_sort_batch_top #(
  parameter int MAX_ITEMS = msb_pkg::MAX_ITEMS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  msb_in_if.sink    in_ch,
  msb_out_if.source out_ch
);
  import msb_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);

  logic                     we0;
  logic                     we1;
  logic [AW-1:0]            waddr;
  logic signed [DATA_W-1:0] wdata;
  logic [AW-1:0]            raddr_a;
  logic [AW-1:0]            raddr_b;
  logic signed [DATA_W-1:0] rd0_a;
  logic signed [DATA_W-1:0] rd0_b;
  logic signed [DATA_W-1:0] rd1_a;
  logic signed [DATA_W-1:0] rd1_b;

  msb_mem #(.DEPTH(MAX_ITEMS), .AW(AW)) u_mem0 (
    .clk         (clk),
    .we          (we0),
    .waddr       (waddr),
    .wdata       (wdata),
    .raddr_a     (raddr_a),
    .raddr_b     (raddr_b),
    .rd_data_a_r (rd0_a),
    .rd_data_b_r (rd0_b)
  );

  msb_mem #(.DEPTH(MAX_ITEMS), .AW(AW)) u_mem1 (
    .clk         (clk),
    .we          (we1),
    .waddr       (waddr),
    .wdata       (wdata),
    .raddr_a     (raddr_a),
    .raddr_b     (raddr_b),
    .rd_data_a_r (rd1_a),
    .rd_data_b_r (rd1_b)
  );

  msb_ctrl #(.MAX_ITEMS(MAX_ITEMS), .AW(AW)) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .we0     (we0),
    .we1     (we1),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rd0_a   (rd0_a),
    .rd0_b   (rd0_b),
    .rd1_a   (rd1_a),
    .rd1_b   (rd1_b)
  );
endmodule
